FILE: design/rta_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rta_pkg
// Shared types and constants for the right triangle angle block: payload
// structs, status codes, arctangent table and the normalizing shift search.
// ----------------------------------------------------------------------------
package rta_pkg;

    localparam int LEG_W       = 32;
    localparam int MAG_W       = LEG_W - 1;
    localparam int ANGLE_W     = 31;
    localparam int THR_W       = 17;
    localparam int DP_W        = 64;
    localparam int Z_W         = ANGLE_W + 2;
    localparam int SH_W        = 6;
    localparam int NORM_MSB    = 60;
    localparam int DEF_CORDIC_STAGES = 30;

    localparam logic [ANGLE_W-1:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [THR_W-1:0]   THR_RESET   = 17'd1;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_NEG  = 2'd1,
        ST_ZERO = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [LEG_W-1:0] leg_a;
        logic signed [LEG_W-1:0] leg_b;
    } t_in;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle_opposite_a;
        logic [ANGLE_W-1:0] angle_opposite_b;
        t_status            status;
    } t_out;

    // atan(2^-i) in unsigned Q1.30, rounded to nearest
    function automatic logic [ANGLE_W-1:0] atan_q30(input int unsigned i);
        logic [ANGLE_W-1:0] t;
        case (i)
            0:  t = 31'd843314857;
            1:  t = 31'd497837829;
            2:  t = 31'd263043837;
            3:  t = 31'd133525159;
            4:  t = 31'd67021687;
            5:  t = 31'd33543516;
            6:  t = 31'd16775851;
            7:  t = 31'd8388437;
            8:  t = 31'd4194283;
            9:  t = 31'd2097149;
            10: t = 31'd1048576;
            11: t = 31'd524288;
            12: t = 31'd262144;
            13: t = 31'd131072;
            14: t = 31'd65536;
            15: t = 31'd32768;
            16: t = 31'd16384;
            17: t = 31'd8192;
            18: t = 31'd4096;
            19: t = 31'd2048;
            20: t = 31'd1024;
            21: t = 31'd512;
            22: t = 31'd256;
            23: t = 31'd128;
            24: t = 31'd64;
            25: t = 31'd32;
            26: t = 31'd16;
            27: t = 31'd8;
            28: t = 31'd4;
            29: t = 31'd2;
            30: t = 31'd1;
            default: t = '0;
        endcase
        return t;
    endfunction

    // left shift that brings the top set bit of m to NORM_MSB
    function automatic logic [SH_W-1:0] norm_shift(input logic [MAG_W-1:0] m);
        int p;
        p = 0;
        for (int i = 0; i < MAG_W; i++) begin
            if (m[i]) begin
                p = i;
            end
        end
        return SH_W'(NORM_MSB - p);
    endfunction

endpackage

FILE: design/right_triangle_angles_from_legs_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// right_triangle_angles_from_legs_top
// Both acute angles of a right triangle from its legs, by an unrolled
// vectoring CORDIC pipeline.
//
//   channel  direction  handshake                    payload
//   in       input      i_in_valid / o_in_ready      i_in_data  (t_in)
//   out      output     o_out_valid / i_out_ready    o_out_data (t_out)
//   cfg      input      i_cfg_we                     i_cfg_wdata (zero threshold)
//
// pipeline registers: input check, shift search, shift, one register stage
// per CORDIC iteration, and the output register behind the clamp.
// one transfer per cycle while the output is ready; each stage holds one item.
// reset clears all valid bits and sets the zero threshold to 1.
// a stage loads whenever it is empty or the next one moves, so bubbles close
// up and the input keeps taking items into free stages while the output stalls.
// ----------------------------------------------------------------------------
module right_triangle_angles_from_legs_top #(
    parameter int CORDIC_STAGES = rta_pkg::DEF_CORDIC_STAGES
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  rta_pkg::t_in             i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output rta_pkg::t_out            o_out_data,
    input  logic                     i_cfg_we,
    input  logic [rta_pkg::THR_W-1:0] i_cfg_wdata
);
    import rta_pkg::*;

    localparam int N = CORDIC_STAGES;

    logic [THR_W-1:0] r_thr;

    // stage 0: range checks
    logic             r_v0;
    logic [MAG_W-1:0] r_a0;
    logic [MAG_W-1:0] r_b0;
    t_status          r_st0;
    t_status          n_st0;
    logic             en0;

    // stage 1: shift search
    logic             r_v1;
    logic [MAG_W-1:0] r_a1;
    logic [MAG_W-1:0] r_b1;
    logic [SH_W-1:0]  r_sh1;
    t_status          r_st1;
    logic             en1;

    // cordic stages, index 0 holds the normalized legs
    logic                    r_cv [0:N];
    logic signed [DP_W-1:0]  r_x  [0:N];
    logic signed [DP_W-1:0]  r_y  [0:N];
    logic signed [Z_W-1:0]   r_z  [0:N];
    t_status                 r_cst[0:N];
    logic                    en_c [0:N];

    // output
    logic               r_o_vld;
    t_out               r_o;
    t_out               n_o;
    logic               en_o;
    logic [ANGLE_W-1:0] n_ang;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    // stall chain
    always_comb begin
        en_o   = !r_o_vld || i_out_ready;
        en_c[N] = !r_cv[N] || en_o;
        for (int k = N - 1; k >= 0; k--) begin
            en_c[k] = !r_cv[k] || en_c[k+1];
        end
        en1 = !r_v1 || en_c[0];
        en0 = !r_v0 || en1;
    end

    assign o_in_ready = en0;

    always_comb begin
        if (i_in_data.leg_a[LEG_W-1] || i_in_data.leg_b[LEG_W-1]) begin
            n_st0 = ST_NEG;
        end else if (($unsigned(i_in_data.leg_a) < LEG_W'(r_thr)) ||
                     ($unsigned(i_in_data.leg_b) < LEG_W'(r_thr))) begin
            n_st0 = ST_ZERO;
        end else begin
            n_st0 = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en0) begin
            r_v0 <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en0) begin
            r_a0  <= i_in_data.leg_a[MAG_W-1:0];
            r_b0  <= i_in_data.leg_b[MAG_W-1:0];
            r_st0 <= n_st0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en1) begin
            r_v1 <= r_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_a1  <= r_a0;
            r_b1  <= r_b0;
            r_sh1 <= norm_shift(r_a0 | r_b0);
            r_st1 <= r_st0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv[0] <= 1'b0;
        end else if (en_c[0]) begin
            r_cv[0] <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_c[0]) begin
            r_x[0]   <= $signed(DP_W'(r_b1) << r_sh1);
            r_y[0]   <= $signed(DP_W'(r_a1) << r_sh1);
            r_z[0]   <= '0;
            r_cst[0] <= r_st1;
        end
    end

    for (genvar k = 1; k <= N; k++) begin : g_cordic
        localparam logic [ANGLE_W-1:0] T = atan_q30(k - 1);
        logic signed [DP_W-1:0] xs;
        logic signed [DP_W-1:0] ys;
        logic signed [DP_W-1:0] n_x;
        logic signed [DP_W-1:0] n_y;
        logic signed [Z_W-1:0]  n_z;

        always_comb begin
            xs = r_x[k-1] >>> (k - 1);
            ys = r_y[k-1] >>> (k - 1);
            if (!r_y[k-1][DP_W-1]) begin
                n_x = r_x[k-1] + ys;
                n_y = r_y[k-1] - xs;
                n_z = r_z[k-1] + $signed(Z_W'(T));
            end else begin
                n_x = r_x[k-1] - ys;
                n_y = r_y[k-1] + xs;
                n_z = r_z[k-1] - $signed(Z_W'(T));
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cv[k] <= 1'b0;
            end else if (en_c[k]) begin
                r_cv[k] <= r_cv[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en_c[k]) begin
                r_x[k]   <= n_x;
                r_y[k]   <= n_y;
                r_z[k]   <= n_z;
                r_cst[k] <= r_cst[k-1];
            end
        end
    end

    // clamp to [0, pi/2], form the complement, and zero both angles on an error status
    always_comb begin
        if (r_z[N][Z_W-1]) begin
            n_ang = '0;
        end else if (r_z[N] > $signed(Z_W'(HALF_PI_Q30))) begin
            n_ang = HALF_PI_Q30;
        end else begin
            n_ang = r_z[N][ANGLE_W-1:0];
        end
        n_o.status = r_cst[N];
        if (r_cst[N] == ST_OK) begin
            n_o.angle_opposite_a = n_ang;
            n_o.angle_opposite_b = HALF_PI_Q30 - n_ang;
        end else begin
            n_o.angle_opposite_a = '0;
            n_o.angle_opposite_b = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (en_o) begin
            r_o_vld <= r_cv[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_o) begin
            r_o <= n_o;
        end
    end

    assign o_out_valid = r_o_vld;
    assign o_out_data  = r_o;

`ifndef ASSERT_OFF
    a_err_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status != ST_OK)) |->
        ((o_out_data.angle_opposite_a == '0) && (o_out_data.angle_opposite_b == '0)))
        else $error("error result with nonzero angle");

    a_sum_half_pi : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status == ST_OK)) |->
        ((32'(o_out_data.angle_opposite_a) + 32'(o_out_data.angle_opposite_b))
            == 32'(HALF_PI_Q30)))
        else $error("angles do not add up to pi/2");

    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    a_ready_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_v0 && r_v1 && r_o_vld && !i_out_ready))
        else $error("input stalled while pipeline has room");
`endif

endmodule

FILE: verif/right_triangle_angles_from_legs_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// right_triangle_angles_from_legs_top_test
// Self-checking bench for the leg-to-angle CORDIC pipeline. A short table of
// probes (extreme legs, negative and zero legs, zero threshold) is followed
// by random phases, each under its own zero threshold. Each accepted pair
// is checked, in order, against a fixed result or a local CORDIC predictor.
// Both channels stall at random, but for the steady phases.
// ----------------------------------------------------------------------------
module right_triangle_angles_from_legs_top_test;

    import rta_pkg::*;

    localparam int  N_STAGES    = DEF_CORDIC_STAGES;
    localparam int  LATENCY     = N_STAGES + 4;
    localparam int  PHASE_ITEMS = 300;
    localparam int  N_PHASES    = 6;
    localparam real RUN_LIMIT   = 5_000_000.0;

    localparam longint ATAN_Q30 [0:30] = '{
        843314857, 497837829, 263043837, 133525159, 67021687,
        33543516, 16775851, 8388437, 4194283, 2097149,
        1048576, 524288, 262144, 131072, 65536,
        32768, 16384, 8192, 4096, 2048,
        1024, 512, 256, 128, 64,
        32, 16, 8, 4, 2,
        1
    };

    localparam t_out NEG_OUT  = '{31'd0, 31'd0, ST_NEG};
    localparam t_out ZERO_OUT = '{31'd0, 31'd0, ST_ZERO};
    localparam t_out FLAT_OUT = '{HALF_PI_Q30, 31'd0, ST_OK};
    localparam t_out CALC     = '{31'd0, 31'd0, ST_OK};

    typedef struct {
        logic [THR_W-1:0] thr;
        logic [31:0]      a;
        logic [31:0]      b;
        bit               typed;
        t_out             want;
    } t_leg_probe;

    t_leg_probe probes [0:21] = '{
        '{17'd1,      32'h0000_0000, 32'h0000_0000, 1'b1, ZERO_OUT},
        '{17'd1,      32'h0000_0001, 32'h0000_0001, 1'b0, CALC},
        '{17'd1,      32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, CALC},
        '{17'd1,      32'h7FFF_FFFF, 32'h0000_0001, 1'b0, CALC},
        '{17'd1,      32'h0000_0001, 32'h7FFF_FFFF, 1'b0, CALC},
        '{17'd1,      32'hFFFF_FFFF, 32'h0000_0005, 1'b1, NEG_OUT},
        '{17'd1,      32'h0000_0005, 32'h8000_0000, 1'b1, NEG_OUT},
        '{17'd1,      32'h8000_0000, 32'h8000_0000, 1'b1, NEG_OUT},
        '{17'd1,      32'h8000_0000, 32'h0000_0000, 1'b1, NEG_OUT},
        '{17'd1,      32'h0001_0000, 32'h0001_0000, 1'b0, CALC},
        '{17'd1,      32'h0003_0000, 32'h0004_0000, 1'b0, CALC},
        '{17'd1,      32'h0000_0000, 32'h7FFF_FFFF, 1'b1, ZERO_OUT},
        '{17'd1,      32'h5555_5555, 32'h2AAA_AAAA, 1'b0, CALC},
        '{17'd65536,  32'h0000_FFFF, 32'h0001_0000, 1'b1, ZERO_OUT},
        '{17'd65536,  32'h0001_0000, 32'h0001_0000, 1'b0, CALC},
        '{17'd65536,  32'hFFFF_FFFF, 32'h0000_0000, 1'b1, NEG_OUT},
        '{17'd0,      32'h0000_0000, 32'h0000_0000, 1'b1, FLAT_OUT},
        '{17'd0,      32'h0000_0000, 32'h0000_0007, 1'b0, CALC},
        '{17'd0,      32'h0000_0009, 32'h0000_0000, 1'b0, CALC},
        '{17'd131071, 32'h0001_FFFE, 32'h0001_FFFF, 1'b1, ZERO_OUT},
        '{17'd131071, 32'h0001_FFFF, 32'h0001_FFFF, 1'b0, CALC},
        '{17'd131071, 32'h7FFF_FFFF, 32'h0001_FFFF, 1'b0, CALC}
    };

    logic             clk = 1'b0;
    logic             rst_n;
    logic             leg_valid;
    logic             leg_ready;
    t_in              leg_data;
    logic             angle_valid;
    logic             angle_ready;
    t_out             angle_data;
    logic             thr_we;
    logic [THR_W-1:0] thr_wdata;

    logic [THR_W-1:0] thr_now;
    bit               steady = 1'b0;
    t_out             angles_due [$];
    t_out             head;
    int               n_bad = 0;

    always #6 clk = ~clk;

    right_triangle_angles_from_legs_top #(
        .CORDIC_STAGES(N_STAGES)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (leg_valid),
        .o_in_ready (leg_ready),
        .i_in_data  (leg_data),
        .o_out_valid(angle_valid),
        .i_out_ready(angle_ready),
        .o_out_data (angle_data),
        .i_cfg_we   (thr_we),
        .i_cfg_wdata(thr_wdata)
    );

    function automatic t_out solve_angles(input t_in d, input logic [THR_W-1:0] thr);
        t_out        r;
        logic [31:0] ra;
        logic [31:0] rb;
        logic [63:0] ua;
        logic [63:0] ub;
        logic [63:0] m;
        longint      x;
        longint      y;
        longint      z;
        longint      xs;
        longint      ys;
        longint      t;
        r  = CALC;
        ra = d.leg_a;
        rb = d.leg_b;
        if (ra[31] || rb[31]) begin
            r.status = ST_NEG;
            return r;
        end
        if (ra < {15'd0, thr} || rb < {15'd0, thr}) begin
            r.status = ST_ZERO;
            return r;
        end
        ua = {32'd0, ra};
        ub = {32'd0, rb};
        m  = ua | ub;
        if (m != 0) begin
            while (m < 64'h1000_0000_0000_0000) begin
                m  = m << 1;
                ua = ua << 1;
                ub = ub << 1;
            end
        end
        x = longint'(ub);
        y = longint'(ua);
        z = 0;
        for (int i = 0; i < N_STAGES; i++) begin
            t  = (i <= 30) ? ATAN_Q30[i] : 0;
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + t;
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - t;
            end
        end
        if (z < 0) begin
            z = 0;
        end
        if (z > longint'(HALF_PI_Q30)) begin
            z = longint'(HALF_PI_Q30);
        end
        r.angle_opposite_a = 31'(z);
        r.angle_opposite_b = 31'(longint'(HALF_PI_Q30) - z);
        r.status           = ST_OK;
        return r;
    endfunction

    // non-negative magnitude of random bit length
    function automatic logic [31:0] draw_mag();
        int unsigned w;
        w = $urandom_range(1, 31);
        return $urandom & ((32'd1 << w) - 32'd1);
    endfunction

    function automatic t_in draw_legs(input logic [THR_W-1:0] thr);
        t_in         d;
        int unsigned kind;
        logic [31:0] a;
        logic [31:0] b;
        kind = $urandom_range(0, 99);
        a    = draw_mag();
        b    = draw_mag();
        if (kind < 70) begin
            if (a < {15'd0, thr}) begin
                a = a + {15'd0, thr};
            end
            if (b < {15'd0, thr}) begin
                b = b + {15'd0, thr};
            end
            if (kind < 5) begin
                a = {15'd0, thr};
            end else if (kind < 10) begin
                b = {15'd0, thr};
            end
        end else if (kind < 80) begin
            if (kind < 75) begin
                a[31] = 1'b1;
            end else begin
                b[31] = 1'b1;
            end
        end else if (kind < 90) begin
            if (thr == 0) begin
                a = 32'd0;
            end else if (kind < 85) begin
                a = $urandom_range(0, thr - 1);
            end else begin
                b = $urandom_range(0, thr - 1);
            end
        end else begin
            a = $urandom;
            b = $urandom;
        end
        d.leg_a = a;
        d.leg_b = b;
        return d;
    endfunction

    task automatic send_legs(input t_in d, input t_out want);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            leg_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        leg_valid <= 1'b1;
        leg_data  <= d;
        @(posedge clk);
        while (!leg_ready) @(posedge clk);
        angles_due.push_back(want);
    endtask

    task automatic drain_angles();
        leg_valid <= 1'b0;
        while (angles_due.size() != 0) @(posedge clk);
    endtask

    task automatic set_threshold(input logic [THR_W-1:0] v);
        drain_angles();
        thr_we    <= 1'b1;
        thr_wdata <= v;
        @(posedge clk);
        thr_we  <= 1'b0;
        thr_now = v;
    endtask

    initial begin
        t_in              d;
        t_out             want;
        logic [THR_W-1:0] thr;
        leg_valid <= 1'b0;
        leg_data  <= '0;
        thr_we    <= 1'b0;
        thr_wdata <= '0;
        rst_n     <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n   <= 1'b1;
        thr_now = THR_RESET;
        @(posedge clk);

        foreach (probes[k]) begin
            if (probes[k].thr != thr_now) begin
                set_threshold(probes[k].thr);
            end
            d.leg_a = probes[k].a;
            d.leg_b = probes[k].b;
            want    = probes[k].typed ? probes[k].want : solve_angles(d, thr_now);
            send_legs(d, want);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0:       thr = THR_W'($urandom_range(1, 65536));
                1:       thr = 17'd1;
                2:       thr = 17'd65536;
                3:       thr = 17'd0;
                4:       thr = THR_W'($urandom_range(0, 131071));
                default: thr = THR_W'($urandom_range(1, 16));
            endcase
            set_threshold(thr);
            steady = (p % 3 == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                d = draw_legs(thr_now);
                send_legs(d, solve_angles(d, thr_now));
            end
        end
        steady = 1'b0;

        drain_angles();
        repeat (LATENCY + 8) @(posedge clk);
        if (n_bad == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        int unsigned stall;
        angle_ready <= 1'b0;
        @(posedge clk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 4);
            if (stall != 0) begin
                angle_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            angle_ready <= 1'b1;
            @(posedge clk);
            while (!angle_valid) @(posedge clk);
        end
    end

    always @(posedge clk) begin
        if (rst_n && angle_valid && angle_ready) begin
            if (angles_due.size() == 0) begin
                $error("unexpected transfer: angle_opposite_a %0d angle_opposite_b %0d status %0d",
                       angle_data.angle_opposite_a, angle_data.angle_opposite_b,
                       angle_data.status);
                n_bad++;
            end else begin
                head = angles_due.pop_front();
                if (angle_data.angle_opposite_a !== head.angle_opposite_a) begin
                    $error("angle_opposite_a: expected %0d, got %0d",
                           head.angle_opposite_a, angle_data.angle_opposite_a);
                    n_bad++;
                end
                if (angle_data.angle_opposite_b !== head.angle_opposite_b) begin
                    $error("angle_opposite_b: expected %0d, got %0d",
                           head.angle_opposite_b, angle_data.angle_opposite_b);
                    n_bad++;
                end
                if (angle_data.status !== head.status) begin
                    $error("status: expected %0d, got %0d", head.status, angle_data.status);
                    n_bad++;
                end
            end
        end
    end

    initial begin
        #(RUN_LIMIT);
        $display("Mismatches found");
        $finish;
    end

endmodule
